### rtl/core/pqme_pkg.sv
// ----------------------------------------------------------------------------
// pqme_pkg: shared types and constants for the max-extract priority queue
// Field widths, operation and status codes, and the result bundle passed
// from the sequencer to the top level.
// ----------------------------------------------------------------------------
package pqme_pkg;

   localparam int VALUE_W = 16;
   localparam int COUNT_W = 5;
   localparam int CAP_W = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes on req_func
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                done;
      status_type          status;
      logic [VALUE_W-1:0]  removed_value;
      logic [COUNT_W-1:0]  entry_count;
   } result_type;

endpackage

### rtl/core/pqme_store.sv
// ----------------------------------------------------------------------------
// pqme_store: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pqme_store #(
   parameter int DEPTH = pqme_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [pqme_pkg::VALUE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [pqme_pkg::VALUE_W-1:0] rd_data
);

   logic [pqme_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [pqme_pkg::VALUE_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pqme_ctrl.sv
// ----------------------------------------------------------------------------
// pqme_ctrl: operation sequencer and shared compare unit
// Appends on insert; on remove, streams entries through one comparator to
// find the earliest maximum, then streams later entries down one place.
// ----------------------------------------------------------------------------
module pqme_ctrl #(
   parameter int DEPTH = pqme_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [pqme_pkg::VALUE_W-1:0]  req_value,
   input  logic [pqme_pkg::CAP_W-1:0]    capacity,
   input  logic                          out_free,
   output pqme_pkg::result_type          result,
   output logic                          mem_wr_en,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output logic [pqme_pkg::VALUE_W-1:0]  mem_wr_data,
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  logic [pqme_pkg::VALUE_W-1:0]  mem_rd_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > pqme_pkg::CAP_W) ? CNT_W : pqme_pkg::CAP_W;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      SHIFT,
      RESULT
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              held_ff, held_in;
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [pqme_pkg::VALUE_W-1:0]  best_val_ff, best_val_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]              src_ff, src_in;
   logic                          wvld_ff, wvld_in;
   logic [IDX_W-1:0]              widx_ff, widx_in;
   pqme_pkg::status_type          res_status_ff, res_status_in;
   logic [pqme_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;

   logic                          full;
   logic                          take;
   logic                          last_cmp;
   logic [CNT_W-1:0]              src_dec;

   assign full = (CMP_W'(held_ff) >= CMP_W'(capacity)) || (held_ff >= CNT_W'(DEPTH));
   assign take = (cmp_idx_ff == '0) || (mem_rd_data > best_val_ff);
   assign last_cmp = (CNT_W'(cmp_idx_ff) + CNT_W'(1)) == held_ff;
   assign src_dec = src_ff - CNT_W'(1);

   // next-state and datapath steering
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      src_in        = src_ff;
      wvld_in       = wvld_ff;
      widx_in       = widx_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = req_value;
      mem_rd_addr   = '0;
      req_ready     = (state_ff == IDLE);
      result.done          = 1'b0;
      result.status        = res_status_ff;
      result.removed_value = res_value_ff;
      result.entry_count   = pqme_pkg::COUNT_W'(held_ff);

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               res_value_in = '0;
               if (req_func == pqme_pkg::FUNC_INSERT) begin
                  state_in = RESULT;
                  if (full) begin
                     res_status_in = pqme_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = held_ff[IDX_W-1:0];
                     held_in       = held_ff + CNT_W'(1);
                     res_status_in = pqme_pkg::STATUS_DONE;
                  end
               end else if (held_ff == '0) begin
                  state_in      = RESULT;
                  res_status_in = pqme_pkg::STATUS_EMPTY;
               end else begin
                  state_in   = SCAN;
                  issue_in   = '0;
                  cmp_vld_in = 1'b0;
               end
            end
         end
         SCAN: begin
            // issue the next read
            if (issue_ff < held_ff) begin
               mem_rd_addr = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = issue_ff[IDX_W-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            // compare returned entry against the running best
            if (cmp_vld_ff) begin
               if (take) begin
                  best_val_in = mem_rd_data;
                  best_idx_in = cmp_idx_ff;
               end
               if (last_cmp) begin
                  state_in     = SHIFT;
                  cmp_vld_in   = 1'b0;
                  wvld_in      = 1'b0;
                  src_in       = CNT_W'(best_idx_in) + CNT_W'(1);
                  res_value_in = best_val_in;
               end
            end
         end
         SHIFT: begin
            // read entry src, write it one place down next cycle
            if (src_ff < held_ff) begin
               mem_rd_addr = src_ff[IDX_W-1:0];
               src_in      = src_ff + CNT_W'(1);
               wvld_in     = 1'b1;
               widx_in     = src_dec[IDX_W-1:0];
            end else begin
               wvld_in       = 1'b0;
               held_in       = held_ff - CNT_W'(1);
               res_status_in = pqme_pkg::STATUS_DONE;
               state_in      = RESULT;
            end
            if (wvld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = widx_ff;
               mem_wr_data = mem_rd_data;
            end
         end
         RESULT: begin
            // hand the item over once the output slot is free
            if (out_free) begin
               result.done = 1'b1;
               state_in    = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and registered datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         held_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         wvld_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         cmp_vld_ff <= cmp_vld_in;
         wvld_ff    <= wvld_in;
      end
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_val_ff   <= best_val_in;
      best_idx_ff   <= best_idx_in;
      src_ff        <= src_in;
      widx_ff       <= widx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("held count exceeds depth");

   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SHIFT) |-> (src_ff <= held_ff))
      else $error("shift source beyond held entries");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (result.done && result.status == pqme_pkg::STATUS_EMPTY) |-> (held_ff == '0))
      else $error("empty status with entries held");

   a_insert_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && req_valid && req_func == pqme_pkg::FUNC_INSERT) |=>
      (held_ff == $past(held_ff) || held_ff == $past(held_ff) + CNT_W'(1)))
      else $error("insert changed count by more than one");

endmodule

### rtl/core/priority_queue_max_extract_core.sv
// ----------------------------------------------------------------------------
// priority_queue_max_extract_core: max-priority queue, unsorted list
// Insert appends; remove-maximum returns the earliest largest entry and
// closes the gap. One result item per request item.
// ----------------------------------------------------------------------------
// An insert moves from IDLE to RESULT, where its result item is registered into
// the output slot once that slot is free; the block then returns to IDLE for the
// next request item. A remove with entries held passes through SCAN and SHIFT
// before it reaches RESULT. In SCAN, all of the held entries stream one per
// cycle through the single read port of the store and one comparator to find
// the maximum, then the entries after it stream back through the same port
// to shift down. The block takes one request item at a time; it accepts the
// next one while the previous result item still waits on rsp_ready, and a
// result item still waiting holds the next one until it leaves.
// capacity_in_use above DEPTH acts as DEPTH; zero refuses every insert.
module priority_queue_max_extract_core #(
   parameter int DEPTH = pqme_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [pqme_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [pqme_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [pqme_pkg::COUNT_W-1:0]  rsp_entry_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pqme_pkg::CAP_W-1:0]    csr_capacity_in_use
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [pqme_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pqme_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [pqme_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [pqme_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                          out_free;
   pqme_pkg::result_type          result;
   logic                          mem_wr_en;
   logic [IDX_W-1:0]              mem_wr_addr;
   logic [pqme_pkg::VALUE_W-1:0]  mem_wr_data;
   logic [IDX_W-1:0]              mem_rd_addr;
   logic [pqme_pkg::VALUE_W-1:0]  mem_rd_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pqme_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_value   (req_value),
      .capacity    (cap_ff),
      .out_free    (out_free),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   pqme_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // capacity register and output slot
   always_comb begin
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (csr_valid) begin
         cap_in = csr_capacity_in_use;
      end
      if (result.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_value_in  = result.removed_value;
         rsp_count_in  = result.entry_count;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= pqme_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule
